@@ hdl/lrf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link reconnect package
// Shared types, codes and reset constants for the link-session controller.
// ----------------------------------------------------------------------------
package lrf_pkg;

    localparam int TIME_BITS_DEF = 32;

    localparam int CMD_W     = 2;
    localparam int NOW_W     = 32;
    localparam int DELAY_W   = 16;
    localparam int TIMEOUT_W = 20;
    localparam int LS_W      = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;

    localparam logic [DELAY_W-1:0]   RST_BASE_DELAY = 16'd5000;
    localparam logic [DELAY_W-1:0]   RST_MAX_DELAY  = 16'd60000;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT    = 20'd30000;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd2;

    localparam logic [LS_W-1:0] LS_IDLE         = 3'd0;
    localparam logic [LS_W-1:0] LS_CHECK        = 3'd1;
    localparam logic [LS_W-1:0] LS_CONNECTING   = 3'd2;
    localparam logic [LS_W-1:0] LS_CONNECTED    = 3'd3;
    localparam logic [LS_W-1:0] LS_DISCONNECTED = 3'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_POLL     = 2'd0,
        CMD_BRK_UP   = 2'd1,
        CMD_BRK_DOWN = 2'd2,
        CMD_BRK_ERR  = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE         = 5'b00001,
        ST_CHECK        = 5'b00010,
        ST_CONNECTING   = 5'b00100,
        ST_CONNECTED    = 5'b01000,
        ST_DISCONNECTED = 5'b10000
    } state_t;

    typedef struct packed {
        logic [DELAY_W-1:0]   base_delay;
        logic [DELAY_W-1:0]   max_delay;
        logic [TIMEOUT_W-1:0] timeout;
    } cfg_t;

    typedef struct packed {
        logic stop;
        logic attempt;
    } strobe_t;

    function automatic logic [LS_W-1:0] state_code(input state_t st);
        logic [LS_W-1:0] code;
        unique case (st)
            ST_IDLE:         code = LS_IDLE;
            ST_CHECK:        code = LS_CHECK;
            ST_CONNECTING:   code = LS_CONNECTING;
            ST_CONNECTED:    code = LS_CONNECTED;
            ST_DISCONNECTED: code = LS_DISCONNECTED;
            default:         code = LS_IDLE;
        endcase
        return code;
    endfunction

endpackage

@@ hdl/lrf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link reconnect channels
// Valid/ready channels for event beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface lrf_evt_if;
    import lrf_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [NOW_W-1:0]   now_ms;
    logic               link_up;
    logic               client_present;
    logic               reconnect_ok;

    modport source (output valid, command, now_ms, link_up, client_present, reconnect_ok,
                    input ready);
    modport sink   (input valid, command, now_ms, link_up, client_present, reconnect_ok,
                    output ready);
endinterface

interface lrf_res_if;
    import lrf_pkg::*;

    logic               valid;
    logic               ready;
    logic [LS_W-1:0]    link_state;
    logic               broker_connected;
    logic               stop_client;
    logic               reconnect_attempt;
    logic [DELAY_W-1:0] retry_delay_ms;

    modport source (output valid, link_state, broker_connected, stop_client,
                    reconnect_attempt, retry_delay_ms,
                    input ready);
    modport sink   (input valid, link_state, broker_connected, stop_client,
                    reconnect_attempt, retry_delay_ms,
                    output ready);
endinterface

interface lrf_cfg_if;
    import lrf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/lrf_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link reconnect configuration registers
// Base delay, delay ceiling and connect timeout, written by index.
// ----------------------------------------------------------------------------
module lrf_cfg_regs (
    input  logic         clk,
    input  logic         rst_n,
    lrf_cfg_if.sink      cfg,
    output lrf_pkg::cfg_t regs
);
    import lrf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_beat;

    assign cfg.ready = 1'b1;
    assign wr_beat   = cfg.valid && cfg.ready;
    assign regs      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_beat)
        begin
            unique case (cfg.index)
                CFG_BASE_DELAY:
                begin
                    cfg_next.base_delay = cfg.data[DELAY_W-1:0];
                end
                CFG_MAX_DELAY:
                begin
                    cfg_next.max_delay = cfg.data[DELAY_W-1:0];
                end
                CFG_TIMEOUT:
                begin
                    cfg_next.timeout = cfg.data[TIMEOUT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_delay <= RST_BASE_DELAY;
            cfg_reg.max_delay  <= RST_MAX_DELAY;
            cfg_reg.timeout    <= RST_TIMEOUT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hdl/lrf_next_state.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link reconnect next-state logic
// Session state, broker flag, entry time and backoff delay for one beat.
// ----------------------------------------------------------------------------
module lrf_next_state #(
    parameter int TIME_BITS = lrf_pkg::TIME_BITS_DEF
) (
    input  lrf_pkg::cmd_t                 command,
    input  logic [TIME_BITS-1:0]          now_t,
    input  logic                          link_up,
    input  logic                          client_present,
    input  logic                          reconnect_ok,
    input  lrf_pkg::cfg_t                 regs,
    input  lrf_pkg::state_t               state_cur,
    input  logic                          flag_cur,
    input  logic [TIME_BITS-1:0]          entry_cur,
    input  logic [lrf_pkg::DELAY_W-1:0]   delay_cur,
    output lrf_pkg::state_t               state_nxt,
    output logic                          flag_nxt,
    output logic [TIME_BITS-1:0]          entry_nxt,
    output logic [lrf_pkg::DELAY_W-1:0]   delay_nxt,
    output lrf_pkg::strobe_t              strobes
);
    import lrf_pkg::*;

    localparam int CMP_W = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;

    logic [TIME_BITS-1:0] elapsed;
    logic [DELAY_W:0]     dbl;
    logic [DELAY_W-1:0]   dbl_clamped;
    logic                 timed_out;
    logic                 delay_due;
    state_t               tgt;

    assign elapsed     = now_t - entry_cur;
    assign timed_out   = CMP_W'(elapsed) > CMP_W'(regs.timeout);
    assign delay_due   = CMP_W'(elapsed) >= CMP_W'(delay_cur);
    assign dbl         = {delay_cur, 1'b0};
    assign dbl_clamped = (dbl > {1'b0, regs.max_delay}) ? regs.max_delay : dbl[DELAY_W-1:0];

    always_comb
    begin
        tgt             = state_cur;
        flag_nxt        = flag_cur;
        entry_nxt       = entry_cur;
        delay_nxt       = delay_cur;
        strobes.stop    = 1'b0;
        strobes.attempt = 1'b0;

        unique case (command)
            CMD_BRK_UP:
            begin
                flag_nxt = 1'b1;
                if (state_cur == ST_CONNECTING)
                begin
                    tgt = ST_CONNECTED;
                end
            end
            CMD_BRK_DOWN:
            begin
                flag_nxt = 1'b0;
                if (state_cur == ST_CONNECTED)
                begin
                    tgt = ST_DISCONNECTED;
                end
            end
            CMD_BRK_ERR:
            begin
                flag_nxt = 1'b0;
                if (state_cur == ST_CONNECTED || state_cur == ST_CONNECTING)
                begin
                    tgt = ST_DISCONNECTED;
                end
            end
            CMD_POLL:
            begin
                unique case (state_cur)
                    ST_CHECK:
                    begin
                        if (link_up)
                        begin
                            tgt = ST_CONNECTING;
                        end
                    end
                    ST_CONNECTING, ST_CONNECTED:
                    begin
                        if (!link_up)
                        begin
                            flag_nxt     = 1'b0;
                            strobes.stop = client_present;
                            tgt          = ST_CHECK;
                        end
                        else if (state_cur == ST_CONNECTING)
                        begin
                            if (!client_present)
                            begin
                                tgt = ST_DISCONNECTED;
                            end
                            else if (flag_cur)
                            begin
                                tgt = ST_CONNECTED;
                            end
                            else if (timed_out)
                            begin
                                tgt = ST_DISCONNECTED;
                            end
                        end
                        else if (!flag_cur)
                        begin
                            tgt = ST_DISCONNECTED;
                        end
                    end
                    ST_DISCONNECTED:
                    begin
                        if (!link_up)
                        begin
                            tgt       = ST_CHECK;
                            delay_nxt = regs.base_delay;
                        end
                        else if (delay_due)
                        begin
                            if (client_present)
                            begin
                                strobes.attempt = 1'b1;
                                if (reconnect_ok)
                                begin
                                    tgt       = ST_CONNECTING;
                                    delay_nxt = regs.base_delay;
                                end
                                else
                                begin
                                    delay_nxt = dbl_clamped;
                                    entry_nxt = now_t;
                                end
                            end
                            else
                            begin
                                tgt = ST_CHECK;
                            end
                        end
                    end
                    ST_IDLE:
                    begin
                        tgt = ST_CHECK;
                    end
                    default:
                    begin
                        tgt = ST_CHECK;
                    end
                endcase
            end
        endcase

        state_nxt = tgt;
        if (tgt != state_cur)
        begin
            entry_nxt = now_t;
        end
    end

endmodule

@@ hdl/link_reconnect_fsm_with_backoff.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link reconnect controller with backoff
// Five-state link-session machine with doubling reconnect delay.
// ----------------------------------------------------------------------------
// Path: an accepted event beat goes to the event register, its result to the
// result register. Throughput: one beat per cycle while results are taken; the
// state update is a single pass of compare and doubling logic between them.
// Reset: state idle, broker flag clear, entry time zero, delay and registers
// at their defaults; both channel registers empty.
// ----------------------------------------------------------------------------
module link_reconnect_fsm_with_backoff #(
    parameter int TIME_BITS = lrf_pkg::TIME_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    lrf_cfg_if.sink   cfg,
    lrf_evt_if.sink   evt,
    lrf_res_if.source res
);
    import lrf_pkg::*;

    cfg_t                 regs;

    logic                 evt_vld_reg;
    logic                 evt_vld_next;
    logic [CMD_W-1:0]     evt_cmd_reg;
    logic [NOW_W-1:0]     evt_now_reg;
    logic                 evt_link_reg;
    logic                 evt_client_reg;
    logic                 evt_ok_reg;

    state_t               state_reg;
    state_t               state_next;
    logic                 flag_reg;
    logic                 flag_next;
    logic [TIME_BITS-1:0] entry_reg;
    logic [TIME_BITS-1:0] entry_next;
    logic [DELAY_W-1:0]   delay_reg;
    logic [DELAY_W-1:0]   delay_next;
    strobe_t              strobes;

    logic                 res_vld_reg;
    logic                 res_vld_next;
    logic [LS_W-1:0]      res_state_reg;
    logic                 res_flag_reg;
    logic                 res_stop_reg;
    logic                 res_attempt_reg;
    logic [DELAY_W-1:0]   res_delay_reg;

    logic                 advance;
    logic                 evt_beat;
    logic [TIME_BITS-1:0] now_t;

    lrf_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    assign advance   = evt_vld_reg && (!res_vld_reg || res.ready);
    assign evt.ready = !evt_vld_reg || advance;
    assign evt_beat  = evt.valid && evt.ready;
    assign now_t     = TIME_BITS'(evt_now_reg);

    lrf_next_state #(
        .TIME_BITS (TIME_BITS)
    ) u_next (
        .command        (cmd_t'(evt_cmd_reg)),
        .now_t          (now_t),
        .link_up        (evt_link_reg),
        .client_present (evt_client_reg),
        .reconnect_ok   (evt_ok_reg),
        .regs           (regs),
        .state_cur      (state_reg),
        .flag_cur       (flag_reg),
        .entry_cur      (entry_reg),
        .delay_cur      (delay_reg),
        .state_nxt      (state_next),
        .flag_nxt       (flag_next),
        .entry_nxt      (entry_next),
        .delay_nxt      (delay_next),
        .strobes        (strobes)
    );

    always_comb
    begin
        priority if (evt_beat)
        begin
            evt_vld_next = 1'b1;
        end
        else if (advance)
        begin
            evt_vld_next = 1'b0;
        end
        else
        begin
            evt_vld_next = evt_vld_reg;
        end

        priority if (advance)
        begin
            res_vld_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_vld_next = 1'b0;
        end
        else
        begin
            res_vld_next = res_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
            state_reg   <= ST_IDLE;
            flag_reg    <= 1'b0;
            entry_reg   <= '0;
            delay_reg   <= RST_BASE_DELAY;
        end
        else
        begin
            evt_vld_reg <= evt_vld_next;
            res_vld_reg <= res_vld_next;
            if (advance)
            begin
                state_reg <= state_next;
                flag_reg  <= flag_next;
                entry_reg <= entry_next;
                delay_reg <= delay_next;
            end
        end
    end

    // hold payload until the beat moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_cmd_reg     <= CMD_POLL;
            evt_now_reg     <= '0;
            evt_link_reg    <= 1'b0;
            evt_client_reg  <= 1'b0;
            evt_ok_reg      <= 1'b0;
            res_state_reg   <= LS_IDLE;
            res_flag_reg    <= 1'b0;
            res_stop_reg    <= 1'b0;
            res_attempt_reg <= 1'b0;
            res_delay_reg   <= '0;
        end
        else
        begin
            if (evt_beat)
            begin
                evt_cmd_reg    <= evt.command;
                evt_now_reg    <= evt.now_ms;
                evt_link_reg   <= evt.link_up;
                evt_client_reg <= evt.client_present;
                evt_ok_reg     <= evt.reconnect_ok;
            end
            if (advance)
            begin
                res_state_reg   <= state_code(state_next);
                res_flag_reg    <= flag_next;
                res_stop_reg    <= strobes.stop;
                res_attempt_reg <= strobes.attempt;
                res_delay_reg   <= delay_next;
            end
        end
    end

    assign res.valid             = res_vld_reg;
    assign res.link_state        = res_state_reg;
    assign res.broker_connected  = res_flag_reg;
    assign res.stop_client       = res_stop_reg;
    assign res.reconnect_attempt = res_attempt_reg;
    assign res.retry_delay_ms    = res_delay_reg;

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg) && $stable(delay_reg) && $stable(entry_reg))
        else $error("session state moved without an event beat");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_vld_reg)
        else $error("processed beat produced no result");

    a_attempt_source: assert property (@(posedge clk) disable iff (!rst_n)
        advance && strobes.attempt |-> state_reg == ST_DISCONNECTED && evt_link_reg)
        else $error("reconnect attempt outside disconnected with link up");

    a_stop_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && res_stop_reg |-> !res_flag_reg && res_state_reg == LS_CHECK)
        else $error("stop strobe without dropping to check link");

endmodule

@@ bench/lrf_session_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link reconnect session checker
// Follows register writes and accepted event beats and keeps its own copy of
// the session state. From these it works out the status each event should
// produce and queues it. Each result beat is compared with the oldest queued
// status. The mismatch count and the number of statuses still waiting go to
// the bench top.
// ----------------------------------------------------------------------------
module lrf_session_checker (
    input  logic clk,
    input  logic rst_n,
    lrf_cfg_if   cfg,
    lrf_evt_if   evt,
    lrf_res_if   res,
    output int   mismatches,
    output int   outstanding
);
    import lrf_pkg::*;

    typedef struct packed {
        logic [LS_W-1:0]    link_state;
        logic               broker_connected;
        logic               stop_client;
        logic               reconnect_attempt;
        logic [DELAY_W-1:0] retry_delay_ms;
    } status_t;

    logic [DELAY_W-1:0]   base_delay;
    logic [DELAY_W-1:0]   max_delay;
    logic [TIMEOUT_W-1:0] connect_timeout;
    logic [LS_W-1:0]      session;
    logic                 brk_flag;
    logic [NOW_W-1:0]     entered_ms;
    logic [DELAY_W-1:0]   backoff;
    status_t              expected_status[$];
    status_t              observed;
    status_t              oldest;

    function automatic void enter(input logic [LS_W-1:0] next, input logic [NOW_W-1:0] now);
        if (session != next)
        begin
            session    = next;
            entered_ms = now;
        end
    endfunction

    function automatic status_t next_session(input cmd_t cmd, input logic [NOW_W-1:0] now,
                                             input logic link, input logic client,
                                             input logic ok);
        logic [NOW_W-1:0] elapsed;
        logic [DELAY_W:0] doubled;
        status_t          st;
        elapsed = now - entered_ms;
        doubled = {backoff, 1'b0};
        st      = '0;
        case (cmd)
            CMD_BRK_UP:
            begin
                brk_flag = 1'b1;
                if (session == LS_CONNECTING)
                    enter(LS_CONNECTED, now);
            end
            CMD_BRK_DOWN:
            begin
                brk_flag = 1'b0;
                if (session == LS_CONNECTED)
                    enter(LS_DISCONNECTED, now);
            end
            CMD_BRK_ERR:
            begin
                brk_flag = 1'b0;
                if (session == LS_CONNECTED || session == LS_CONNECTING)
                    enter(LS_DISCONNECTED, now);
            end
            CMD_POLL:
            begin
                case (session)
                    LS_CHECK:
                    begin
                        if (link)
                            enter(LS_CONNECTING, now);
                    end
                    LS_CONNECTING, LS_CONNECTED:
                    begin
                        if (!link)
                        begin
                            brk_flag       = 1'b0;
                            st.stop_client = client;
                            enter(LS_CHECK, now);
                        end
                        else if (session == LS_CONNECTING)
                        begin
                            if (!client)
                                enter(LS_DISCONNECTED, now);
                            else if (brk_flag)
                                enter(LS_CONNECTED, now);
                            else if (elapsed > connect_timeout)
                                enter(LS_DISCONNECTED, now);
                        end
                        else if (!brk_flag)
                            enter(LS_DISCONNECTED, now);
                    end
                    LS_DISCONNECTED:
                    begin
                        if (!link)
                        begin
                            enter(LS_CHECK, now);
                            backoff = base_delay;
                        end
                        else if (elapsed >= backoff)
                        begin
                            if (client)
                            begin
                                st.reconnect_attempt = 1'b1;
                                if (ok)
                                begin
                                    enter(LS_CONNECTING, now);
                                    backoff = base_delay;
                                end
                                else
                                begin
                                    backoff    = (doubled > max_delay) ? max_delay
                                                                       : doubled[DELAY_W-1:0];
                                    entered_ms = now;
                                end
                            end
                            else
                                enter(LS_CHECK, now);
                        end
                    end
                    default:
                        enter(LS_CHECK, now);
                endcase
            end
            default:
            begin
            end
        endcase
        st.link_state       = session;
        st.broker_connected = brk_flag;
        st.retry_delay_ms   = backoff;
        return st;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_delay      = RST_BASE_DELAY;
            max_delay       = RST_MAX_DELAY;
            connect_timeout = RST_TIMEOUT;
            session         = LS_IDLE;
            brk_flag        = 1'b0;
            entered_ms      = '0;
            backoff         = RST_BASE_DELAY;
            expected_status.delete();
            mismatches      = 0;
            outstanding    <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                observed = '{res.link_state, res.broker_connected, res.stop_client,
                             res.reconnect_attempt, res.retry_delay_ms};
                if (expected_status.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing expected: state %0d flag %0b",
                                 $time, observed.link_state, observed.broker_connected,
                                 " stop %0b attempt %0b delay %0d", observed.stop_client,
                                 observed.reconnect_attempt, observed.retry_delay_ms);
                end
                else
                begin
                    oldest = expected_status.pop_front();
                    if (observed !== oldest)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected state %0d flag %0b stop %0b attempt %0b",
                                     $time, oldest.link_state, oldest.broker_connected,
                                     oldest.stop_client, oldest.reconnect_attempt,
                                     " delay %0d, got state %0d flag %0b stop %0b",
                                     oldest.retry_delay_ms, observed.link_state,
                                     observed.broker_connected, observed.stop_client,
                                     " attempt %0b delay %0d",
                                     observed.reconnect_attempt, observed.retry_delay_ms);
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_BASE_DELAY: base_delay      = cfg.data[DELAY_W-1:0];
                    CFG_MAX_DELAY:  max_delay       = cfg.data[DELAY_W-1:0];
                    CFG_TIMEOUT:    connect_timeout = cfg.data[TIMEOUT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (evt.valid && evt.ready)
                expected_status.push_back(next_session(cmd_t'(evt.command), evt.now_ms,
                                                       evt.link_up, evt.client_present,
                                                       evt.reconnect_ok));
            outstanding <= expected_status.size();
        end
    end

endmodule

@@ bench/link_reconnect_fsm_with_backoff_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link reconnect controller bench
// Resets the controller once and then runs a directed walk through every
// state, timeout, backoff step and broker event, with session time wrapping
// past zero. After that come random sessions under several register settings,
// including zero, maximum and clamping values, while the event and result
// sides idle at different rates. The session checker gives the verdict.
// ----------------------------------------------------------------------------
module link_reconnect_fsm_with_backoff_tb;
    import lrf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
    localparam int                   PHASE_BEATS = 300;
    localparam logic [NOW_W-1:0]     WRAP_START  = 32'hFFFF_F000;

    logic             clk   = 1'b0;
    logic             rst_n = 1'b0;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               mismatches;
    int               outstanding;
    logic [NOW_W-1:0] clock_ms;

    lrf_cfg_if cfg();
    lrf_evt_if evt();
    lrf_res_if res();

    link_reconnect_fsm_with_backoff dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .evt   (evt),
        .res   (res)
    );

    lrf_session_checker session_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .evt         (evt),
        .res         (res),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            res.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] value);
        cfg.index <= idx;
        cfg.data  <= value;
        cfg.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    task automatic send_event(input cmd_t cmd, input logic [NOW_W-1:0] now,
                              input logic link, input logic client, input logic ok);
        while ($urandom_range(99) < send_idle_pct)
        begin
            evt.valid <= 1'b0;
            @(posedge clk);
        end
        evt.command        <= cmd;
        evt.now_ms         <= now;
        evt.link_up        <= link;
        evt.client_present <= client;
        evt.reconnect_ok   <= ok;
        evt.valid          <= 1'b1;
        do
            @(posedge clk);
        while (!evt.ready);
    endtask

    task automatic drain;
        evt.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_sessions(input int count, input int unsigned step_max);
        cmd_t        cmd;
        int unsigned roll;
        logic        link;
        logic        client;
        logic        ok;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            cmd  = (roll < 70) ? CMD_POLL : cmd_t'($urandom_range(3, 1));
            roll = $urandom_range(99);
            if (roll < 4)
                clock_ms = $urandom;
            else if (roll < 12)
                clock_ms = clock_ms + $urandom_range(step_max * 4);
            else
                clock_ms = clock_ms + $urandom_range(step_max);
            link   = ($urandom_range(99) < 85);
            client = ($urandom_range(99) < 90);
            ok     = 1'($urandom_range(1));
            send_event(cmd, clock_ms, link, client, ok);
        end
    endtask

    initial
    begin
        logic [CFG_DAT_W-1:0] base_val;
        logic [CFG_DAT_W-1:0] max_val;
        logic [CFG_DAT_W-1:0] timeout_val;
        int unsigned          step_max;

        evt.valid          = 1'b0;
        evt.command        = CMD_POLL;
        evt.now_ms         = '0;
        evt.link_up        = 1'b0;
        evt.client_present = 1'b0;
        evt.reconnect_ok   = 1'b0;
        cfg.valid          = 1'b0;
        cfg.index          = CFG_BASE_DELAY;
        cfg.data           = '0;
        clock_ms           = $urandom;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_event(CMD_POLL,     WRAP_START,                  1'b0, 1'b1, 1'b1);
        send_event(CMD_POLL,     WRAP_START + 32'd10,         1'b0, 1'b1, 1'b1);
        send_event(CMD_BRK_DOWN, WRAP_START + 32'd15,         1'b0, 1'b1, 1'b0);
        send_event(CMD_POLL,     WRAP_START + 32'd20,         1'b1, 1'b1, 1'b0);
        send_event(CMD_POLL,     WRAP_START + 32'd30020,      1'b1, 1'b1, 1'b0);
        send_event(CMD_POLL,     WRAP_START + 32'd30021,      1'b1, 1'b1, 1'b0);
        send_event(CMD_POLL,     WRAP_START + 32'd35020,      1'b1, 1'b1, 1'b1);
        send_event(CMD_POLL,     WRAP_START + 32'd35021,      1'b1, 1'b1, 1'b0);
        send_event(CMD_POLL,     WRAP_START + 32'd45021,      1'b1, 1'b1, 1'b0);
        send_event(CMD_POLL,     WRAP_START + 32'd65021,      1'b1, 1'b1, 1'b0);
        send_event(CMD_POLL,     WRAP_START + 32'd105021,     1'b1, 1'b1, 1'b0);
        send_event(CMD_BRK_UP,   WRAP_START + 32'd110000,     1'b1, 1'b1, 1'b0);
        send_event(CMD_POLL,     WRAP_START + 32'd165021,     1'b1, 1'b1, 1'b1);
        send_event(CMD_POLL,     WRAP_START + 32'd165030,     1'b1, 1'b1, 1'b0);
        send_event(CMD_POLL,     WRAP_START + 32'd165040,     1'b0, 1'b1, 1'b0);
        send_event(CMD_POLL,     WRAP_START + 32'd165050,     1'b1, 1'b1, 1'b0);
        send_event(CMD_BRK_UP,   WRAP_START + 32'd165060,     1'b1, 1'b1, 1'b0);
        send_event(CMD_BRK_DOWN, WRAP_START + 32'd165070,     1'b1, 1'b1, 1'b0);
        send_event(CMD_POLL,     WRAP_START + 32'd165080,     1'b0, 1'b0, 1'b0);
        send_event(CMD_POLL,     WRAP_START + 32'd165090,     1'b1, 1'b0, 1'b0);
        send_event(CMD_POLL,     WRAP_START + 32'd165100,     1'b0, 1'b0, 1'b0);
        send_event(CMD_POLL,     WRAP_START + 32'd165110,     1'b1, 1'b1, 1'b0);
        send_event(CMD_POLL,     WRAP_START + 32'd165120,     1'b1, 1'b0, 1'b1);
        send_event(CMD_POLL,     WRAP_START + 32'd175120,     1'b1, 1'b0, 1'b1);
        send_event(CMD_POLL,     WRAP_START + 32'd175130,     1'b1, 1'b1, 1'b0);
        send_event(CMD_BRK_ERR,  WRAP_START + 32'd175140,     1'b1, 1'b1, 1'b0);
        drain;

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    base_val    = 20'd5000;
                    max_val     = 20'd60000;
                    timeout_val = 20'd30000;
                    step_max    = 40000;
                end
                1:
                begin
                    base_val    = 20'd0;
                    max_val     = 20'd0;
                    timeout_val = 20'd0;
                    step_max    = 3;
                end
                2:
                begin
                    base_val    = 20'h0FFFF;
                    max_val     = 20'h0FFFF;
                    timeout_val = 20'd1000000;
                    step_max    = 200000;
                end
                3:
                begin
                    base_val    = 20'd7;
                    max_val     = 20'd100;
                    timeout_val = 20'd50;
                    step_max    = 120;
                end
                4:
                begin
                    base_val    = 20'hF0032;
                    max_val     = 20'hA0014;
                    timeout_val = 20'hFFFFF;
                    step_max    = 80;
                end
                default:
                begin
                    base_val    = 20'd1;
                    max_val     = 20'h0FFFF;
                    timeout_val = 20'd5;
                    step_max    = 40;
                end
            endcase
            send_idle_pct  = (p % 4 == 1) ? 77 : (p % 4 == 3) ? 23 : 0;
            recv_stall_pct = (p % 4 == 2) ? 77 : (p % 4 == 3) ? 23 : 0;
            write_reg(CFG_BASE_DELAY, base_val);
            write_reg(CFG_MAX_DELAY, max_val);
            write_reg(CFG_TIMEOUT, timeout_val);
            if (p == 2)
                write_reg(CFG_SPARE, 20'hFFFFF);
            if (p == 0)
            begin
                run_sessions(PHASE_BEATS / 2, step_max);
                drain;
                run_sessions(PHASE_BEATS / 2, step_max);
            end
            else
                run_sessions(PHASE_BEATS, step_max);
            drain;
        end

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
